### rtl/core/assert_macros.svh
// assertion macros for the rtl of the lms adaptive filter
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/lms_pkg.sv
// shared widths, register codes and multiplier op codes for the lms adaptive filter
// no dependencies; used by lms_mac, lms_seq and lms_adaptive_filter
package lms_pkg;

  localparam int TAP_W   = 16;
  localparam int W_W     = 24;
  localparam int ERR_W   = 18;
  localparam int SQ_W    = 32;
  localparam int STEP_W  = 16;
  localparam int REF_W   = 16;
  localparam int DIFF_W  = 25;
  localparam int EXR_W   = 25;
  localparam int ME_W    = 35;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int FRAC_SHIFT = 20;
  localparam int DEV_SHIFT  = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_WEIGHT = 1'd1;

  localparam logic [STEP_W-1:0]       RST_STEP_SIZE  = 16'd328;
  localparam logic signed [REF_W-1:0] RST_REF_WEIGHT = 16'sd2253;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_Y,
    OP_EX,
    OP_DEV,
    OP_SQE,
    OP_SQX,
    OP_MU,
    OP_UPD
  } op_t;

endpackage

### rtl/core/lms_mac.sv
// shared signed multiplier with registered product and op tag
// depends on lms_pkg
module lms_mac #(
  parameter int TIDX_W = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lms_pkg::op_t                        op,
  input  logic [TIDX_W-1:0]                   tap,
  input  logic signed [lms_pkg::MUL_A_W-1:0]  a,
  input  logic signed [lms_pkg::MUL_B_W-1:0]  b,
  output lms_pkg::op_t                        op_q,
  output logic [TIDX_W-1:0]                   tap_q,
  output logic signed [lms_pkg::PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= lms_pkg::OP_NOP;
    end else begin
      op_q <= op;
    end
    tap_q <= tap;
    prod  <= lms_pkg::PROD_W'(a) * lms_pkg::PROD_W'(b);
  end

endmodule

### rtl/core/lms_seq.sv
// sequencer that issues the multiplier ops for each word one per cycle, with a gap step before the update
// depends on lms_pkg
module lms_seq #(
  parameter int TAPS   = 4,
  parameter int TIDX_W = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              out_free,
  output lms_pkg::op_t      op,
  output logic [TIDX_W-1:0] tap,
  output logic              idle,
  output logic              finish
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_Y,
    S_EX,
    S_DEV,
    S_SQE,
    S_SQX,
    S_MU,
    S_GAP,
    S_UPD,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t            state;
  logic [TIDX_W-1:0] cnt;
  logic              last;

  assign last   = (cnt == TIDX_W'(TAPS - 1));
  assign tap    = cnt;
  assign idle   = (state == S_IDLE);
  assign finish = (state == S_OUT) && out_free;

  always_comb begin
    case (state)
      S_Y:     op = lms_pkg::OP_Y;
      S_EX:    op = lms_pkg::OP_EX;
      S_DEV:   op = lms_pkg::OP_DEV;
      S_SQE:   op = lms_pkg::OP_SQE;
      S_SQX:   op = lms_pkg::OP_SQX;
      S_MU:    op = lms_pkg::OP_MU;
      S_UPD:   op = lms_pkg::OP_UPD;
      default: op = lms_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) state <= S_Y;
        end
        S_Y: begin
          cnt <= last ? '0 : cnt + 1'b1;
          if (last) state <= S_EX;
        end
        S_EX: begin
          cnt <= last ? '0 : cnt + 1'b1;
          if (last) state <= S_DEV;
        end
        S_DEV: begin
          cnt <= last ? '0 : cnt + 1'b1;
          if (last) state <= S_SQE;
        end
        S_SQE: state <= S_SQX;
        S_SQX: state <= S_MU;
        S_MU:  state <= S_GAP;
        S_GAP: begin
          cnt   <= '0;
          state <= S_UPD;
        end
        S_UPD: begin
          cnt <= last ? '0 : cnt + 1'b1;
          if (last) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_OUT;
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/lms_adaptive_filter.sv
// lms adaptive filter top level: registers, operand select, accumulators, weight update
// depends on lms_pkg, lms_seq, lms_mac and assert_macros.svh
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata taps and desired, s_tuser restart
// m_*      out  m_tvalid/m_tready  m_tdata errors, squares, new weights
// cfg_*    in   cfg_wr_en          cfg_index, cfg_wr_data
//
// a word's products go one per cycle through the single shared 36x26 multiplier
// outside the gap and drain steps; s_tready is high only when idle
// the result register lets the next word be accepted while a result waits;
// a finished word holds in its last step until the result register is free
// reset is synchronous; weights clear to zero, registers take their defaults
`include "assert_macros.svh"

module lms_adaptive_filter #(
  parameter int TAPS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // taps 0 .. TAPS-1, then desired
  input  logic [(TAPS+1)*lms_pkg::TAP_W-1:0]   s_tdata,
  // restart
  input  logic [0:0]                           s_tuser,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // error_value, error_squared, excess_squared, deviation_squared,
  // weight_0 .. weight_(TAPS-1), zero pad
  output logic [((114+24*TAPS+7)/8)*8-1:0]     m_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_wr_en,
  input  logic [lms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lms_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);

  localparam int TIDX_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int GROW     = $clog2(TAPS) + 1;
  localparam int ACC_Y_W  = 40 + GROW;
  localparam int ACC_X_W  = 41 + GROW;
  localparam int ACC_D_W  = 50 + GROW;
  localparam int YR_W     = ACC_Y_W + 1 - lms_pkg::FRAC_SHIFT;
  localparam int EF_W     = YR_W + 1;
  localparam int DR_W     = lms_pkg::PROD_W + 1 - lms_pkg::FRAC_SHIFT;
  localparam int DV_W     = ACC_D_W + 1 - lms_pkg::DEV_SHIFT;
  localparam int OUT_BITS = 18 + 3 * 32 + TAPS * 24;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int W_OFF    = lms_pkg::ERR_W + 3 * lms_pkg::SQ_W;

  localparam logic signed [ACC_Y_W:0] RND_Y = (ACC_Y_W + 1)'(2 ** (lms_pkg::FRAC_SHIFT - 1));
  localparam logic signed [ACC_X_W:0] RND_X = (ACC_X_W + 1)'(2 ** (lms_pkg::FRAC_SHIFT - 1));
  localparam logic signed [ACC_D_W:0] RND_D = (ACC_D_W + 1)'(2 ** (lms_pkg::DEV_SHIFT - 1));
  localparam logic signed [lms_pkg::PROD_W:0] RND_P =
    (lms_pkg::PROD_W + 1)'(2 ** (lms_pkg::FRAC_SHIFT - 1));
  localparam logic signed [EF_W-1:0] ERR_MAX = EF_W'(2 ** (lms_pkg::ERR_W - 1) - 1);
  localparam logic signed [EF_W-1:0] ERR_MIN = EF_W'(-(2 ** (lms_pkg::ERR_W - 1)));
  localparam logic signed [DR_W:0]   W_MAX   = (DR_W + 1)'(2 ** (lms_pkg::W_W - 1) - 1);
  localparam logic signed [DR_W:0]   W_MIN   = (DR_W + 1)'(-(2 ** (lms_pkg::W_W - 1)));

  // configuration
  logic [lms_pkg::STEP_W-1:0]       step_size;
  logic signed [lms_pkg::REF_W-1:0] ref_weight;
  logic signed [lms_pkg::W_W-1:0]   ref20;

  // word and state
  logic signed [lms_pkg::TAP_W-1:0] taps [TAPS];
  logic signed [lms_pkg::TAP_W-1:0] desired;
  logic signed [lms_pkg::W_W-1:0]   weights [TAPS];

  // accumulators and intermediates
  logic signed [ACC_Y_W-1:0]        acc_y;
  logic signed [ACC_X_W-1:0]        acc_ex;
  logic signed [ACC_D_W-1:0]        acc_dev;
  logic signed [lms_pkg::ERR_W-1:0] err;
  logic signed [lms_pkg::EXR_W-1:0] exr;
  logic signed [lms_pkg::ME_W-1:0]  me;
  logic [lms_pkg::SQ_W-1:0]         esq;
  logic [lms_pkg::SQ_W-1:0]         xsq;

  logic [OUT_W-1:0]                 out_data;
  logic                             out_valid;

  // control
  logic                             accept;
  logic                             seq_idle;
  logic                             seq_finish;
  logic                             out_free;
  lms_pkg::op_t                     mac_op;
  lms_pkg::op_t                     mac_op_q;
  logic [TIDX_W-1:0]                mac_tap;
  logic [TIDX_W-1:0]                mac_tap_q;
  logic signed [lms_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lms_pkg::MUL_B_W-1:0] mul_b;
  logic signed [lms_pkg::PROD_W-1:0]  prod;

  // combinational helpers
  logic signed [lms_pkg::TAP_W-1:0]  u_sel;
  logic signed [lms_pkg::W_W-1:0]    w_sel;
  logic signed [lms_pkg::DIFF_W-1:0] diff_sel;
  logic signed [ACC_Y_W:0]           y_sum;
  logic signed [YR_W-1:0]            y_rnd;
  logic signed [EF_W-1:0]            e_full;
  logic signed [lms_pkg::ERR_W-1:0]  e_sat;
  logic signed [ACC_X_W:0]           x_sum;
  logic signed [ACC_D_W:0]           dv_sum;
  logic [DV_W-1:0]                   dv_rnd;
  logic [lms_pkg::SQ_W-1:0]          dev_sat;
  logic [lms_pkg::SQ_W-1:0]          sq_sat;
  logic signed [lms_pkg::PROD_W:0]   d_sum;
  logic signed [DR_W-1:0]            d_rnd;
  logic signed [lms_pkg::W_W-1:0]    w_upd_old;
  logic signed [DR_W:0]              w_sum;
  logic signed [lms_pkg::W_W-1:0]    w_upd;
  logic [OUT_W-1:0]                  out_next;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = seq_idle;
  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign ref20    = {ref_weight, 8'h00};

  lms_seq #(
    .TAPS   (TAPS),
    .TIDX_W (TIDX_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_free (out_free),
    .op       (mac_op),
    .tap      (mac_tap),
    .idle     (seq_idle),
    .finish   (seq_finish)
  );

  lms_mac #(
    .TIDX_W (TIDX_W)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .op    (mac_op),
    .tap   (mac_tap),
    .a     (mul_a),
    .b     (mul_b),
    .op_q  (mac_op_q),
    .tap_q (mac_tap_q),
    .prod  (prod)
  );

  // operand select
  assign u_sel    = taps[mac_tap];
  assign w_sel    = weights[mac_tap];
  assign diff_sel = lms_pkg::DIFF_W'(ref20) - lms_pkg::DIFF_W'(w_sel);

  always_comb begin
    case (mac_op)
      lms_pkg::OP_Y: begin
        mul_a = lms_pkg::MUL_A_W'(u_sel);
        mul_b = lms_pkg::MUL_B_W'(w_sel);
      end
      lms_pkg::OP_EX: begin
        mul_a = lms_pkg::MUL_A_W'(u_sel);
        mul_b = lms_pkg::MUL_B_W'(diff_sel);
      end
      lms_pkg::OP_DEV: begin
        mul_a = lms_pkg::MUL_A_W'(diff_sel);
        mul_b = lms_pkg::MUL_B_W'(diff_sel);
      end
      lms_pkg::OP_SQE: begin
        mul_a = lms_pkg::MUL_A_W'(err);
        mul_b = lms_pkg::MUL_B_W'(err);
      end
      lms_pkg::OP_SQX: begin
        mul_a = lms_pkg::MUL_A_W'(exr);
        mul_b = lms_pkg::MUL_B_W'(exr);
      end
      lms_pkg::OP_MU: begin
        mul_a = lms_pkg::MUL_A_W'(err);
        mul_b = lms_pkg::MUL_B_W'(step_size);
      end
      lms_pkg::OP_UPD: begin
        mul_a = lms_pkg::MUL_A_W'(me);
        mul_b = lms_pkg::MUL_B_W'(u_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // error from the filter output, round half up then saturate
  assign y_sum  = (ACC_Y_W + 1)'(acc_y) + RND_Y;
  assign y_rnd  = y_sum[ACC_Y_W:lms_pkg::FRAC_SHIFT];
  assign e_full = EF_W'(desired) - EF_W'(y_rnd);
  assign e_sat  = (e_full > ERR_MAX) ? lms_pkg::ERR_W'(ERR_MAX) :
                  (e_full < ERR_MIN) ? lms_pkg::ERR_W'(ERR_MIN) :
                  e_full[lms_pkg::ERR_W-1:0];

  assign x_sum  = (ACC_X_W + 1)'(acc_ex) + RND_X;

  // deviation sum is never negative
  assign dv_sum  = (ACC_D_W + 1)'(acc_dev) + RND_D;
  assign dv_rnd  = dv_sum[ACC_D_W:lms_pkg::DEV_SHIFT];
  assign dev_sat = (|dv_rnd[DV_W-1:lms_pkg::SQ_W]) ? '1 : dv_rnd[lms_pkg::SQ_W-1:0];

  // squares are never negative
  assign sq_sat = (|prod[lms_pkg::PROD_W-1:lms_pkg::SQ_W]) ? '1 : prod[lms_pkg::SQ_W-1:0];

  // weight update
  assign d_sum     = (lms_pkg::PROD_W + 1)'(prod) + RND_P;
  assign d_rnd     = d_sum[lms_pkg::PROD_W:lms_pkg::FRAC_SHIFT];
  assign w_upd_old = weights[mac_tap_q];
  assign w_sum     = (DR_W + 1)'(d_rnd) + (DR_W + 1)'(w_upd_old);
  assign w_upd     = (w_sum > W_MAX) ? lms_pkg::W_W'(W_MAX) :
                     (w_sum < W_MIN) ? lms_pkg::W_W'(W_MIN) :
                     w_sum[lms_pkg::W_W-1:0];

  always_comb begin
    out_next = '0;
    out_next[lms_pkg::ERR_W-1:0] = err;
    out_next[lms_pkg::ERR_W +: lms_pkg::SQ_W] = esq;
    out_next[lms_pkg::ERR_W + lms_pkg::SQ_W +: lms_pkg::SQ_W] = xsq;
    out_next[lms_pkg::ERR_W + 2 * lms_pkg::SQ_W +: lms_pkg::SQ_W] = dev_sat;
    for (int i = 0; i < TAPS; i++) begin
      out_next[W_OFF + i * lms_pkg::W_W +: lms_pkg::W_W] = weights[i];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= lms_pkg::RST_STEP_SIZE;
      ref_weight <= lms_pkg::RST_REF_WEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lms_pkg::CFG_STEP_SIZE:  step_size  <= cfg_wr_data;
        lms_pkg::CFG_REF_WEIGHT: ref_weight <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < TAPS; i++) begin
        taps[i] <= s_tdata[i * lms_pkg::TAP_W +: lms_pkg::TAP_W];
      end
      desired <= s_tdata[TAPS * lms_pkg::TAP_W +: lms_pkg::TAP_W];
    end
  end

  // weights
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        weights[i] <= '0;
      end
    end else if (accept && s_tuser[0]) begin
      for (int i = 0; i < TAPS; i++) begin
        weights[i] <= '0;
      end
    end else if (mac_op_q == lms_pkg::OP_UPD) begin
      weights[mac_tap_q] <= w_upd;
    end
  end

  // accumulators and products
  always_ff @(posedge clk) begin
    err <= e_sat;
    exr <= x_sum[lms_pkg::FRAC_SHIFT +: lms_pkg::EXR_W];
    if (accept) begin
      acc_y   <= '0;
      acc_ex  <= '0;
      acc_dev <= '0;
    end else begin
      case (mac_op_q)
        lms_pkg::OP_Y:   acc_y   <= acc_y + prod[ACC_Y_W-1:0];
        lms_pkg::OP_EX:  acc_ex  <= acc_ex + prod[ACC_X_W-1:0];
        lms_pkg::OP_DEV: acc_dev <= acc_dev + prod[ACC_D_W-1:0];
        lms_pkg::OP_SQE: esq     <= sq_sat;
        lms_pkg::OP_SQX: xsq     <= sq_sat;
        lms_pkg::OP_MU:  me      <= prod[lms_pkg::ME_W-1:0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (seq_finish) begin
      out_data <= out_next;
    end
  end

  `ASSERT_IMPLIES(a_idle_no_op, clk, rst, s_tready, mac_op == lms_pkg::OP_NOP, "multiplier op issued while idle")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !s_tready, "ready stayed high after accept")
  `ASSERT_NEXT(a_finish_sets_valid, clk, rst, seq_finish, m_tvalid, "finished word did not reach output")
  `ASSERT_IMPLIES(a_finish_when_free, clk, rst, seq_finish, out_free, "result loaded over a pending word")

endmodule

### tb/lms_result_check.sv
`timescale 1ns / 1ps
// result checker for the lms adaptive filter: tracks registers and weights, predicts each result
// word and compares it field by field; depends on lms_pkg only
module lms_result_check
  import lms_pkg::*;
#(
  parameter int TAPS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [(TAPS+1)*TAP_W-1:0]          s_tdata,
  input  logic [0:0]                         s_tuser,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [((114+24*TAPS+7)/8)*8-1:0]   m_tdata,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_wr_data,
  output int                                 fail_count,
  output int                                 due_count
);

  typedef struct packed {
    logic [TAPS-1:0][W_W-1:0] w;
    logic [SQ_W-1:0]          dsq;
    logic [SQ_W-1:0]          xsq;
    logic [SQ_W-1:0]          esq;
    logic [ERR_W-1:0]         err;
  } lms_out_t;

  logic [STEP_W-1:0]       mu;
  logic signed [REF_W-1:0] ref_w;
  longint                  wt [TAPS];
  lms_out_t                results_due [$];
  int                      mism;

  initial mism = 0;

  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_signed(input longint v, input int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic [SQ_W-1:0] clamp_u32(input longint v);
    if (v < 0) return '0;
    if (v > longint'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
    return v[SQ_W-1:0];
  endfunction

  // one lms step on the tracked weights
  function automatic lms_out_t adapt_weights(input logic restart,
                                             input logic [(TAPS+1)*TAP_W-1:0] word);
    lms_out_t r;
    longint u [TAPS];
    longint d, ref20, acc_y, acc_x, acc_d, diff, e, xr, delta;
    if (restart)
      for (int i = 0; i < TAPS; i++) wt[i] = 0;
    for (int i = 0; i < TAPS; i++) u[i] = longint'($signed(word[TAP_W*i +: TAP_W]));
    d = longint'($signed(word[TAP_W*TAPS +: TAP_W]));
    ref20 = longint'(ref_w) * 256;
    acc_y = 0;
    acc_x = 0;
    acc_d = 0;
    for (int i = 0; i < TAPS; i++) begin
      diff = ref20 - wt[i];
      acc_y += u[i] * wt[i];
      acc_x += u[i] * diff;
      acc_d += diff * diff;
    end
    e = clamp_signed(d - round_shr(acc_y, FRAC_SHIFT), ERR_W);
    r.err = e[ERR_W-1:0];
    r.esq = clamp_u32(e * e);
    xr = round_shr(acc_x, FRAC_SHIFT);
    r.xsq = clamp_u32(xr * xr);
    r.dsq = clamp_u32(round_shr(acc_d, DEV_SHIFT));
    for (int i = 0; i < TAPS; i++) begin
      delta = round_shr(longint'(mu) * u[i] * e, FRAC_SHIFT);
      wt[i] = clamp_signed(wt[i] + delta, W_W);
      r.w[i] = wt[i][W_W-1:0];
    end
    return r;
  endfunction

  task automatic field_check(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mism < 10) $display("mismatch in %s: expected %h, got %h", fname, want, got);
      mism++;
    end
  endtask

  always @(posedge clk) begin
    lms_out_t want;
    lms_out_t got;
    if (rst) begin
      mu = RST_STEP_SIZE;
      ref_w = RST_REF_WEIGHT;
      for (int i = 0; i < TAPS; i++) wt[i] = 0;
      results_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_STEP_SIZE:  mu = cfg_wr_data;
          CFG_REF_WEIGHT: ref_w = cfg_wr_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.err = m_tdata[17:0];
        got.esq = m_tdata[49:18];
        got.xsq = m_tdata[81:50];
        got.dsq = m_tdata[113:82];
        for (int i = 0; i < TAPS; i++) got.w[i] = m_tdata[114 + W_W*i +: W_W];
        if (results_due.size() == 0) begin
          if (mism < 10) $display("unexpected result word %h", m_tdata);
          mism++;
        end else begin
          want = results_due.pop_front();
          field_check("error_value", 32'(want.err), 32'(got.err));
          field_check("error_squared", want.esq, got.esq);
          field_check("excess_squared", want.xsq, got.xsq);
          field_check("deviation_squared", want.dsq, got.dsq);
          for (int i = 0; i < TAPS; i++)
            field_check($sformatf("weight_%0d", i), 32'(want.w[i]), 32'(got.w[i]));
        end
      end
      if (s_tvalid && s_tready) results_due.push_back(adapt_weights(s_tuser[0], s_tdata));
    end
    due_count <= results_due.size();
    fail_count <= mism;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// top of the lms adaptive filter testbench: clock, reset, stimulus, register writes and verdict
// depends on lms_pkg, lms_adaptive_filter and lms_result_check
module testbench;
  import lms_pkg::*;

  localparam int TAPS  = 4;
  localparam int IN_W  = (TAPS + 1) * TAP_W;
  localparam int OUT_W = ((114 + 24*TAPS + 7) / 8) * 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_W-1:0]       s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_STEP_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  int                    fail_count;
  int                    due_count;
  bit                    sender_burst = 1'b0;
  bit                    hold_req = 1'b0;
  logic signed [15:0]    plant_ref = RST_REF_WEIGHT;

  lms_adaptive_filter #(.TAPS(TAPS)) dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  lms_result_check #(.TAPS(TAPS)) result_check (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .due_count(due_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #7_200_000;
    $display("lms_adaptive_filter verification failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [IN_W-1:0] pack_word(input logic signed [15:0] t0, t1, t2, t3, d);
    return {d, t3, t2, t1, t0};
  endfunction

  task automatic push_word(input bit restart, input logic [IN_W-1:0] word);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= restart;
    do @(posedge clk); while (!s_tready);
    gap = sender_burst ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  task automatic load_regs(input logic [15:0] step, input logic signed [15:0] refw);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_STEP_SIZE;
    cfg_wr_data <= step;
    @(posedge clk);
    cfg_index <= CFG_REF_WEIGHT;
    cfg_wr_data <= refw;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    plant_ref = refw;
  endtask

  // mostly adaptation runs against a plant at the reference weight, the rest raw noise
  task automatic random_phase(input int n_items);
    int left, run, shift;
    logic [IN_W-1:0] word;
    logic signed [15:0] t;
    longint tap_sum, dval;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        run = $urandom_range(6, 30);
        for (int k = 0; k < run && left > 0; k++) begin
          tap_sum = 0;
          for (int i = 0; i < TAPS; i++) begin
            shift = $urandom_range(0, 4);
            t = $signed(16'($urandom)) >>> shift;
            word[16*i +: 16] = t;
            tap_sum += t;
          end
          dval = ((tap_sum * plant_ref + 2048) >>> 12) + int'($urandom_range(0, 64)) - 32;
          if (dval > 32767) dval = 32767;
          if (dval < -32768) dval = -32768;
          word[16*TAPS +: 16] = dval[15:0];
          push_word(k == 0, word);
          left--;
        end
      end else begin
        for (int i = 0; i <= TAPS; i++) begin
          case ($urandom_range(0, 5))
            0:       word[16*i +: 16] = 16'h7FFF;
            1:       word[16*i +: 16] = 16'h8000;
            default: word[16*i +: 16] = 16'($urandom);
          endcase
        end
        push_word($urandom_range(0, 7) == 0, word);
        left--;
      end
    end
  endtask

  // receiver: random ready pattern, one long hold-off on request
  initial begin
    int run, gap;
    bit held;
    held = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        for (int n = 0; n < 400; n++) @(posedge clk);
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // register defaults, field extremes
    push_word(1'b1, pack_word(0, 0, 0, 0, 0));
    push_word(1'b1, pack_word(32767, 32767, 32767, 32767, 32767));
    push_word(1'b0, pack_word(-32768, -32768, -32768, -32768, -32768));
    push_word(1'b0, pack_word(32767, -32768, 32767, -32768, 0));
    push_word(1'b0, pack_word(-32768, 32767, -32768, 32767, 32767));
    push_word(1'b0, pack_word(1, -1, 1, -1, -1));
    push_word(1'b0, pack_word(4096, 4096, 4096, 4096, 2253));
    push_word(1'b1, pack_word(4096, 4096, 4096, 4096, -32768));
    push_word(1'b0, pack_word(0, 0, 0, 0, 32767));
    push_word(1'b0, pack_word(-1, -1, -1, -1, -32768));
    wait_drained();

    // largest step drives weights and error into saturation
    load_regs(16'hFFFF, 16'sh7FFF);
    push_word(1'b1, pack_word(32767, 32767, 32767, 32767, -32768));
    push_word(1'b0, pack_word(32767, 32767, 32767, 32767, 32767));
    push_word(1'b0, pack_word(-32768, -32768, -32768, -32768, 32767));
    push_word(1'b0, pack_word(32767, 32767, 32767, 32767, -32768));
    push_word(1'b0, pack_word(-32768, -32768, -32768, -32768, -32768));
    push_word(1'b0, pack_word(32767, -32768, 32767, -32768, 32767));
    wait_drained();

    load_regs(16'd1000, 16'sd2253);
    random_phase(90);
    wait_drained();
    load_regs(16'd0, -16'sd32768);
    random_phase(40);
    wait_drained();
    load_regs(16'hFFFF, -16'sd32768);
    random_phase(40);
    wait_drained();

    // back-to-back words while the receiver holds off
    load_regs(16'd4000, 16'sd0);
    sender_burst = 1'b1;
    hold_req = 1'b1;
    random_phase(60);
    sender_burst = 1'b0;
    wait_drained();

    load_regs(16'($urandom), 16'($urandom));
    random_phase(80);
    wait_drained();
    load_regs(16'd20000, 16'sd32767);
    random_phase(50);
    wait_drained();
    load_regs(16'($urandom_range(1, 4000)), 16'($urandom));
    random_phase(90);
    wait_drained();

    repeat (60) @(posedge clk);
    if (fail_count == 0 && due_count == 0)
      $display("lms_adaptive_filter verification clean");
    else
      $display("lms_adaptive_filter verification failed");
    $finish;
  end

endmodule
